FILE: rtl/ft12_pkg.sv
`default_nettype none

package ft12_pkg;

	localparam logic [7:0] START_BYTE = 8'h68;
	localparam logic [7:0] END_BYTE   = 8'h16;
	localparam logic [7:0] MAX_ASDU   = 8'd253;
	localparam logic [7:0] LEN_EXTRA  = 8'd2;

	localparam logic [2:0] HDR_LAST_OPEN  = 3'd5;
	localparam logic [2:0] HDR_LAST_CLOSE = 3'd7;
	localparam logic [2:0] DAT_LAST_OPEN  = 3'd0;
	localparam logic [2:0] DAT_LAST_CLOSE = 3'd2;

	typedef enum logic {
		OP_START = 1'b0,
		OP_DATA  = 1'b1
	} op_t;

	typedef struct packed {
		op_t        kind;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] lfield;
		logic [7:0] csum;
		logic       close;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

FILE: rtl/ft12_front.sv
`default_nettype none

module ft12_front
	import ft12_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,
	input  wire logic        s_tuser,
	input  wire q_stat_t     q_stat,
	output logic             push,
	output job_t             job
);

	logic [7:0] sum_q;
	logic [7:0] rem_q;
	logic       open_q;

	logic       accept;
	op_t        op;
	logic [7:0] ctrl;
	logic [7:0] addr;
	logic [7:0] alen;
	logic [7:0] data;
	logic [7:0] alen_sat;
	logic [7:0] hdr_sum;
	logic [7:0] dat_sum;
	logic [7:0] rem_dec;

	assign op   = op_t'(s_tuser);
	assign ctrl = s_tdata[7:0];
	assign addr = s_tdata[15:8];
	assign alen = s_tdata[23:16];
	assign data = s_tdata[31:24];

	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;

	assign alen_sat = (alen > MAX_ASDU) ? MAX_ASDU : alen;
	assign hdr_sum  = ctrl + addr;
	assign dat_sum  = sum_q + data;
	assign rem_dec  = rem_q - 8'd1;

	always_comb begin
		job.kind   = op;
		job.lfield = alen_sat + LEN_EXTRA;
		job.b1     = addr;
		if (op == OP_START) begin
			job.b0    = ctrl;
			job.csum  = hdr_sum;
			job.close = (alen_sat == 8'd0);
		end else begin
			job.b0    = data;
			job.csum  = dat_sum;
			job.close = (rem_dec == 8'd0);
		end
	end

	assign push = accept && ((op == OP_START) || open_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= 8'd0;
			rem_q  <= 8'd0;
			open_q <= 1'b0;
		end else if (push) begin
			if (job.close) begin
				sum_q  <= 8'd0;
				rem_q  <= 8'd0;
				open_q <= 1'b0;
			end else if (op == OP_START) begin
				sum_q  <= hdr_sum;
				rem_q  <= alen_sat;
				open_q <= 1'b1;
			end else begin
				sum_q  <= dat_sum;
				rem_q  <= rem_dec;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ft12_queue.sv
`default_nettype none

module ft12_queue
	import ft12_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t wr_job,
	input  wire logic pop,
	output job_t      rd_job,
	output q_stat_t   q_stat
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign q_stat.full  = (count_q == CW'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign rd_job       = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("push into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

FILE: rtl/ft12_back.sv
`default_nettype none

module ft12_back
	import ft12_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire job_t       rd_job,
	input  wire q_stat_t    q_stat,
	output logic            pop,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,
	output logic            m_tlast
);

	logic [2:0] step_q;
	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic       m_tlast_q;

	logic       adv;
	logic       load;
	logic [2:0] last_step;
	logic [7:0] nxt_byte;
	logic       nxt_last;

	always_comb begin
		nxt_last = 1'b0;
		if (rd_job.kind == OP_START) begin
			last_step = rd_job.close ? HDR_LAST_CLOSE : HDR_LAST_OPEN;
			unique case (step_q)
				3'd0:    nxt_byte = START_BYTE;
				3'd1:    nxt_byte = rd_job.lfield;
				3'd2:    nxt_byte = rd_job.lfield;
				3'd3:    nxt_byte = START_BYTE;
				3'd4:    nxt_byte = rd_job.b0;
				3'd5:    nxt_byte = rd_job.b1;
				3'd6:    nxt_byte = rd_job.csum;
				default: begin
					nxt_byte = END_BYTE;
					nxt_last = 1'b1;
				end
			endcase
		end else begin
			last_step = rd_job.close ? DAT_LAST_CLOSE : DAT_LAST_OPEN;
			unique case (step_q)
				3'd0:    nxt_byte = rd_job.b0;
				3'd1:    nxt_byte = rd_job.csum;
				default: begin
					nxt_byte = END_BYTE;
					nxt_last = 1'b1;
				end
			endcase
		end
	end

	assign adv  = !m_tvalid_q || m_tready;
	assign load = adv && !q_stat.empty;
	assign pop  = load && (step_q == last_step);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= 3'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (adv) begin
				m_tvalid_q <= !q_stat.empty;
			end
			if (pop) begin
				step_q <= 3'd0;
			end else if (load) begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= nxt_byte;
			m_tlast_q <= nxt_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

`ifndef SYNTHESIS
	a_last_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata == END_BYTE))
		else $error("frame end marked on a byte other than the end byte");
	a_pop_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> load)
		else $error("job retired without sending a byte");
	a_rose_from_job: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!q_stat.empty))
		else $error("output raised with no job queued");
`endif

endmodule

`default_nettype wire

FILE: rtl/ft12_variable_frame_builder.sv
`default_nettype none

// Builds variable-length telecontrol frames as a byte stream. A start item (tuser low) sends
// 0x68, L, L, 0x68, control and address with L the ASDU length (capped at 253) plus two; each data item
// (tuser high) sends its byte, and the last one of the frame is followed by the checksum and
// 0x16 with tlast. A start item with a zero length closes the frame at once, a data item with
// no open frame is dropped, and a new start abandons an open frame without a trailer. The
// input takes one item per cycle while the job queue between the classifier and the
// serialiser has room; the serialiser sends one byte per cycle from its output register while
// m_tready allows, so a data item yields one byte, a closing data item three, a start item six
// or eight. QUEUE_DEPTH (at least two) sets how far the input may run ahead of the output.
module ft12_variable_frame_builder
	import ft12_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // control_byte, link_address, asdu_length, data_byte
	input  wire logic        s_tuser,  // operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // out_byte
	output logic             m_tlast   // frame_end
);

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	job_t    wr_job;
	job_t    rd_job;

	ft12_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.push     (push),
		.job      (wr_job)
	);

	ft12_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.q_stat (q_stat)
	);

	ft12_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_job   (rd_job),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import ft12_pkg::*;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
	} frame_byte_t;

	class frame_scoreboard;
		frame_byte_t expected_bytes[$];
		logic [7:0]  running_sum;
		logic [7:0]  bytes_left;
		logic        frame_open;
		int          mismatches;
		int          bytes_checked;
		int          items_seen;
		int          frames_closed;
		int          frames_abandoned;
		int          strays_dropped;

		function new();
			running_sum = '0;
			bytes_left = '0;
			frame_open = 1'b0;
			mismatches = 0;
			bytes_checked = 0;
			items_seen = 0;
			frames_closed = 0;
			frames_abandoned = 0;
			strays_dropped = 0;
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		function void push_byte(logic [7:0] value, logic last);
			frame_byte_t e;
			e.out_byte = value;
			e.frame_end = last;
			expected_bytes.push_back(e);
		endfunction

		function void close_frame();
			push_byte(running_sum, 1'b0);
			push_byte(END_BYTE, 1'b1);
			running_sum = '0;
			bytes_left = '0;
			frame_open = 1'b0;
			frames_closed++;
		endfunction

		function void note_item(op_t op, logic [31:0] fields);
			logic [7:0] ctrl;
			logic [7:0] addr;
			logic [7:0] len;
			logic [7:0] data;
			logic [7:0] lfield;
			ctrl = fields[7:0];
			addr = fields[15:8];
			len = fields[23:16];
			data = fields[31:24];
			items_seen++;
			if (op == OP_START) begin
				if (frame_open)
					frames_abandoned++;
				if (len > MAX_ASDU)
					len = MAX_ASDU;
				lfield = len + LEN_EXTRA;
				push_byte(START_BYTE, 1'b0);
				push_byte(lfield, 1'b0);
				push_byte(lfield, 1'b0);
				push_byte(START_BYTE, 1'b0);
				push_byte(ctrl, 1'b0);
				push_byte(addr, 1'b0);
				running_sum = ctrl + addr;
				bytes_left = len;
				frame_open = 1'b1;
				if (bytes_left == 8'd0)
					close_frame();
			end else if (!frame_open) begin
				strays_dropped++;
			end else begin
				push_byte(data, 1'b0);
				running_sum = running_sum + data;
				if (bytes_left != 8'd0)
					bytes_left = bytes_left - 8'd1;
				if (bytes_left == 8'd0)
					close_frame();
			end
		endfunction

		function void report_mismatch(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("MISMATCH at %0t: %s", $realtime, msg);
		endfunction

		function void check_byte(logic [7:0] value, logic last);
			frame_byte_t e;
			bytes_checked++;
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h, frame_end %0b", value, last));
				return;
			end
			e = expected_bytes.pop_front();
			if (e.out_byte !== value || e.frame_end !== last)
				report_mismatch($sformatf("out_byte exp %02h got %02h, frame_end exp %0b got %0b",
					e.out_byte, value, e.frame_end, last));
		endfunction
	endclass

	localparam int QUIET_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 240;
	localparam int LONG_LEN = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	frame_scoreboard frames;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	int random_items = 0;
	logic open_frame = 1'b0;

	ft12_variable_frame_builder u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				frames.note_item(op_t'(s_tuser), s_tdata);
			if (m_tvalid && m_tready)
				frames.check_byte(m_tdata, m_tlast);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles, %0d bytes still awaited.",
					QUIET_LIMIT, frames.pending());
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	task automatic send_item(input op_t op, input logic [7:0] ctrl, input logic [7:0] addr,
			input logic [7:0] len, input logic [7:0] data);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {data, len, addr, ctrl};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic start_frame(input logic [7:0] ctrl, input logic [7:0] addr,
			input logic [7:0] len);
		send_item(OP_START, ctrl, addr, len, 8'($urandom));
	endtask

	task automatic put_data(input logic [7:0] data);
		send_item(OP_DATA, 8'($urandom), 8'($urandom), 8'($urandom), data);
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (frames.pending() != 0);
	endtask

	// Mostly complete frames of a few bytes; now and then one is cut short by the next start.
	task automatic random_frame();
		int len;
		int n_data;
		len = ($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(10);
		start_frame(8'($urandom), 8'($urandom), 8'(len));
		n_data = len;
		if (len > 0 && (len > 12 || $urandom_range(7) == 0))
			n_data = $urandom_range((len > 6) ? 5 : len - 1);
		repeat (n_data) put_data(8'($urandom));
		open_frame = (n_data < len);
		random_items += 1 + n_data;
	endtask

	initial begin
		int phase;
		frames = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		put_data(8'h5a);
		start_frame(8'h00, 8'h00, 8'd0);
		start_frame(8'hff, 8'hff, 8'd0);
		start_frame(8'h12, 8'h34, 8'd2);
		put_data(8'hff);
		put_data(8'h00);
		put_data(8'hc3);
		start_frame(8'h80, 8'h7f, 8'd255);
		put_data(8'hff);
		put_data(8'h01);
		start_frame(8'h55, 8'haa, 8'd1);
		put_data(8'h7f);
		start_frame(8'hfe, 8'h01, 8'd254);
		put_data(8'hab);
		start_frame(8'h01, 8'hfe, 8'd253);
		put_data(8'h80);
		start_frame(8'hc0, 8'h40, 8'd3);
		put_data(8'hf0);
		put_data(8'h0f);
		put_data(8'hff);

		for (phase = 0; phase < 4; phase++) begin
			wait_for_drain();
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 59;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 59;
				end
				default: begin
					idle_pct = 14;
					stall_pct = 14;
				end
			endcase
			if (phase == 2) begin
				start_frame(8'($urandom), 8'($urandom), 8'(LONG_LEN));
				repeat (LONG_LEN) put_data(8'($urandom));
				open_frame = 1'b0;
				random_items += 1 + LONG_LEN;
			end
			while (random_items < (phase + 1) * RANDOM_ITEMS / 4) begin
				if (!open_frame && $urandom_range(9) == 0) begin
					put_data(8'($urandom));
					random_items++;
				end else begin
					random_frame();
				end
			end
		end

		wait_for_drain();
		repeat (20) @(negedge clk);
		$display("Sent %0d items: %0d frames closed, %0d abandoned by a new start,",
			frames.items_seen, frames.frames_closed, frames.frames_abandoned);
		$display("%0d stray bytes dropped; checked %0d output bytes under four idling patterns.",
			frames.strays_dropped, frames.bytes_checked);
		if (frames.mismatches == 0 && frames.pending() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
